[rtl/env_sensor_compensation_unit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the environmental sensor compensation unit
// Each macro expands to a labeled concurrent assertion, or to nothing when
// NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef ENV_SENSOR_COMPENSATION_UNIT_ASSERT_SVH
`define ENV_SENSOR_COMPENSATION_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// ante implies cons on the same edge
`define ESC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// expr never holds
`define ESC_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error(msg);

`else

`define ESC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define ESC_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

[rtl/esc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_pkg
// Shared types and constants of the environmental sensor compensation unit.
// ----------------------------------------------------------------------------
package esc_pkg;

	localparam int QUEUE_DEPTH_DEF = 4;
	localparam int IN_DATA_W       = 56;
	localparam int OUT_DATA_W      = 80;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 48;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TEMP_CALIB  = 3'd0,
		REG_PRESS_1_3   = 3'd1,
		REG_PRESS_4_6   = 3'd2,
		REG_PRESS_7_9   = 3'd3,
		REG_HUM_1_3     = 3'd4,
		REG_HUM_4_6     = 3'd5
	} reg_idx_t;

	// raw calibration words
	typedef struct packed {
		logic [47:0] temp;
		logic [47:0] p13;
		logic [47:0] p46;
		logic [47:0] p79;
		logic [31:0] h13;
		logic [31:0] h46;
	} calib_t;

	// front result handed to the pressure back end
	typedef struct packed {
		logic signed [31:0] tfine;
		logic [23:0]        temperature;
		logic [16:0]        humidity;
		logic [19:0]        raw_press;
	} front_res_t;

endpackage

[rtl/esc_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_front
// Accepts raw samples and runs the 32-bit temperature and humidity
// compensation in a nine-stage pipeline.
// ----------------------------------------------------------------------------
module esc_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// raw_press [19:0], raw_temp [39:20], raw_hum [55:40]
	input  logic [esc_pkg::IN_DATA_W-1:0] s_tdata,
	input  esc_pkg::calib_t               calib,
	input  logic                          q_full,
	output logic                          q_push,
	output esc_pkg::front_res_t           q_data
);

	// calibration decode
	logic signed [31:0] t2, t3, h1, h2, h3, h4, h5, h6;
	always_comb begin
		t2 = 32'($signed(calib.temp[31:16]));
		t3 = 32'($signed(calib.temp[47:32]));
		h1 = {24'b0, calib.h13[7:0]};
		h2 = 32'($signed(calib.h13[23:8]));
		h3 = {24'b0, calib.h13[31:24]};
		h4 = 32'($signed(calib.h46[11:0]));
		h5 = 32'($signed(calib.h46[23:12]));
		h6 = 32'($signed(calib.h46[31:24]));
	end

	logic en;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;

	// whole pipeline moves unless the last stage is blocked by a full queue
	assign en       = !vld_s9 || !q_full;
	assign s_tready = en;
	assign q_push   = vld_s9 && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0; vld_s2 <= 1'b0; vld_s3 <= 1'b0;
			vld_s4 <= 1'b0; vld_s5 <= 1'b0; vld_s6 <= 1'b0;
			vld_s7 <= 1'b0; vld_s8 <= 1'b0; vld_s9 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
			vld_s2 <= vld_s1; vld_s3 <= vld_s2; vld_s4 <= vld_s3;
			vld_s5 <= vld_s4; vld_s6 <= vld_s5; vld_s7 <= vld_s6;
			vld_s8 <= vld_s7; vld_s9 <= vld_s8;
		end
	end

	logic signed [31:0] m1_s1, dd_s1, v1_s2, m2_s2, tfine_s3;
	logic signed [31:0] pa_s4, pb_s4, pc_s4, x_s5, y0_s5, x_s6, y1_s6;
	logic signed [31:0] vv_s7, vv_s8, ss_s8, vv_s9, w_s9, sv;
	logic signed [31:0] tfine_s4, tfine_s5, tfine_s6, tfine_s7, tfine_s8, tfine_s9;
	logic [23:0]        temp_s4, temp_s5, temp_s6, temp_s7, temp_s8, temp_s9;
	logic [15:0]        hum_s1, hum_s2, hum_s3, hum_s4;
	logic [19:0]        rp_s1, rp_s2, rp_s3, rp_s4, rp_s5, rp_s6, rp_s7, rp_s8, rp_s9;

	// input split and first temperature terms
	logic [19:0]        raw_press, raw_temp;
	logic [15:0]        raw_hum;
	logic signed [31:0] e1, dt;
	always_comb begin
		raw_press = s_tdata[19:0];
		raw_temp  = s_tdata[39:20];
		raw_hum   = s_tdata[55:40];
		e1 = $signed({15'b0, raw_temp[19:3]}) - $signed({15'b0, calib.temp[15:0], 1'b0});
		dt = $signed({16'b0, raw_temp[19:4]}) - $signed({16'b0, calib.temp[15:0]});
	end

	// temperature result and humidity base value from fine temperature
	logic signed [31:0] tt, hv_base;
	logic [23:0]        temp_sat;
	always_comb begin
		tt = ((tfine_s3 <<< 2) + tfine_s3 + 32'sd128) >>> 8;
		if (tt > 32'sd8388607)       temp_sat = 24'h7FFFFF;
		else if (tt < -32'sd8388608) temp_sat = 24'h800000;
		else                         temp_sat = tt[23:0];
		hv_base = tfine_s3 - 32'sd76800;
	end

	assign sv = vv_s7 >>> 15;

	// datapath stages
	always_ff @(posedge clk) begin
		if (en) begin
			m1_s1  <= e1 * t2;
			dd_s1  <= dt * dt;
			hum_s1 <= raw_hum;
			rp_s1  <= raw_press;

			v1_s2  <= m1_s1 >>> 11;
			m2_s2  <= (dd_s1 >>> 12) * t3;
			hum_s2 <= hum_s1;
			rp_s2  <= rp_s1;

			tfine_s3 <= v1_s2 + (m2_s2 >>> 14);
			hum_s3   <= hum_s2;
			rp_s3    <= rp_s2;

			pa_s4    <= h5 * hv_base;
			pb_s4    <= hv_base * h6;
			pc_s4    <= hv_base * h3;
			temp_s4  <= temp_sat;
			tfine_s4 <= tfine_s3;
			hum_s4   <= hum_s3;
			rp_s4    <= rp_s3;

			x_s5     <= ($signed({2'b0, hum_s4, 14'b0}) - (h4 <<< 20) - pa_s4
				+ 32'sd16384) >>> 15;
			y0_s5    <= (pb_s4 >>> 10) * ((pc_s4 >>> 11) + 32'sd32768);
			temp_s5  <= temp_s4;
			tfine_s5 <= tfine_s4;
			rp_s5    <= rp_s4;

			y1_s6    <= ((y0_s5 >>> 10) + 32'sd2097152) * h2 + 32'sd8192;
			x_s6     <= x_s5;
			temp_s6  <= temp_s5;
			tfine_s6 <= tfine_s5;
			rp_s6    <= rp_s5;

			vv_s7    <= x_s6 * (y1_s6 >>> 14);
			temp_s7  <= temp_s6;
			tfine_s7 <= tfine_s6;
			rp_s7    <= rp_s6;

			ss_s8    <= sv * sv;
			vv_s8    <= vv_s7;
			temp_s8  <= temp_s7;
			tfine_s8 <= tfine_s7;
			rp_s8    <= rp_s7;

			w_s9     <= (ss_s8 >>> 7) * h1;
			vv_s9    <= vv_s8;
			temp_s9  <= temp_s8;
			tfine_s9 <= tfine_s8;
			rp_s9    <= rp_s8;
		end
	end

	// final humidity clamp
	logic signed [31:0] hv;
	logic [31:0]        hc;
	always_comb begin
		hv = vv_s9 - (w_s9 >>> 4);
		if (hv[31])                   hc = 32'd0;
		else if (hv > 32'sd419430400) hc = 32'd419430400;
		else                          hc = hv;
		q_data.tfine       = tfine_s9;
		q_data.temperature = temp_s9;
		q_data.humidity    = hc[28:12];
		q_data.raw_press   = rp_s9;
	end

endmodule

[rtl/esc_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_queue
// Short first-word-fall-through queue between the front pipeline and the
// pressure back end.
// ----------------------------------------------------------------------------
`include "env_sensor_compensation_unit_assert.svh"

module esc_queue #(
	parameter int DEPTH = esc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  esc_pkg::front_res_t wdata,
	input  logic                pop,
	output esc_pkg::front_res_t rdata,
	output logic                full,
	output logic                empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	esc_pkg::front_res_t entry_q [DEPTH];
	logic [PW-1:0]       wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]       cnt_q;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = entry_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= wdata;
	end

	`ESC_ASSERT_NEVER(a_no_overflow, clk, arst_n, push && full, "queue write while full")
	`ESC_ASSERT_NEVER(a_no_underflow, clk, arst_n, pop && empty, "queue read while empty")

endmodule

[rtl/esc_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_back
// Sequential 64-bit pressure compensation: ten wrapped 64-bit products on one
// shared 32x32 multiplier, a bit-serial signed divider and an output register.
// ----------------------------------------------------------------------------
`include "env_sensor_compensation_unit_assert.svh"

module esc_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  esc_pkg::calib_t                calib,
	input  logic                           q_empty,
	input  esc_pkg::front_res_t            q_data,
	output logic                           q_pop,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// temperature [23:0], pressure [55:24], press_valid [56], humidity [73:57]
	output logic [esc_pkg::OUT_DATA_W-1:0] m_tdata
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MUL  = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_FIN  = 4'b1000
	} state_t;

	// product steps in order
	typedef enum logic [3:0] {
		OP_AA  = 4'd0,
		OP_B6  = 4'd1,
		OP_B5  = 4'd2,
		OP_C3  = 4'd3,
		OP_C2  = 4'd4,
		OP_X1  = 4'd5,
		OP_NUM = 4'd6,
		OP_Q9  = 4'd7,
		OP_QQ  = 4'd8,
		OP_P8  = 4'd9
	} op_t;

	state_t state_q;
	op_t    op_q;
	logic [1:0]  ph_q;
	logic [5:0]  cnt_q;
	logic        na_q, nb_q, pv_q, ov_q;
	logic [63:0] a_q, aa_q, b_q, c_q, x_q, pq_q, acc_q, pp_q, dvd_q, dvs_q, rem_q;
	logic [23:0] temp_q, o_temp_q;
	logic [16:0] hum_q, o_hum_q;
	logic [19:0] rp_q;
	logic [31:0] o_pres_q;
	logic        o_pv_q;

	// calibration decode
	logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
	always_comb begin
		p1 = {48'b0, calib.p13[15:0]};
		p2 = 64'($signed(calib.p13[31:16]));
		p3 = 64'($signed(calib.p13[47:32]));
		p4 = 64'($signed(calib.p46[15:0]));
		p5 = 64'($signed(calib.p46[31:16]));
		p6 = 64'($signed(calib.p46[47:32]));
		p7 = 64'($signed(calib.p79[15:0]));
		p8 = 64'($signed(calib.p79[31:16]));
		p9 = 64'($signed(calib.p79[47:32]));
	end

	// operand select for the current product
	logic [63:0] opa, opb, num_base, qv;
	always_comb begin
		num_base = ((64'd1048576 - {44'b0, rp_q}) << 31) - b_q;
		qv       = 64'($signed(pq_q) >>> 13);
		case (op_q)
			OP_AA:   begin opa = a_q;      opb = a_q;       end
			OP_B6:   begin opa = aa_q;     opb = p6;        end
			OP_B5:   begin opa = a_q;      opb = p5;        end
			OP_C3:   begin opa = aa_q;     opb = p3;        end
			OP_C2:   begin opa = a_q;      opb = p2;        end
			OP_X1:   begin opa = c_q;      opb = p1;        end
			OP_NUM:  begin opa = num_base; opb = 64'd3125;  end
			OP_Q9:   begin opa = p9;       opb = qv;        end
			OP_QQ:   begin opa = c_q;      opb = qv;        end
			OP_P8:   begin opa = p8;       opb = pq_q;      end
			default: begin opa = '0;       opb = '0;        end
		endcase
	end

	// shared 32x32 multiplier, partial product picked by phase
	logic [31:0] mx, my;
	logic [63:0] mp, prod;
	always_comb begin
		mx   = (ph_q == 2'd2) ? opa[63:32] : opa[31:0];
		my   = (ph_q == 2'd1) ? opb[63:32] : opb[31:0];
		mp   = {32'b0, mx} * {32'b0, my};
		prod = acc_q + {pp_q[31:0], 32'b0};
	end

	// divider step
	logic [64:0] dr, dr_sub;
	logic        dge;
	logic [63:0] quo;
	always_comb begin
		dr     = {rem_q, dvd_q[63]};
		dr_sub = dr - {1'b0, dvs_q};
		dge    = !dr_sub[64];
		quo    = {dvd_q[62:0], dge};
	end

	// final scaling and saturation
	logic [63:0] pr;
	logic [31:0] pres_sat;
	always_comb begin
		pr = 64'($signed(c_q) >>> 8) + (p7 << 4);
		if (pr[63])             pres_sat = 32'd0;
		else if (|pr[63:32])    pres_sat = 32'hFFFFFFFF;
		else                    pres_sat = pr[31:0];
	end

	logic out_load;
	assign q_pop    = (state_q == ST_IDLE) && !q_empty;
	assign out_load = (state_q == ST_FIN) && (!ov_q || m_tready);
	assign m_tvalid = ov_q;
	assign m_tdata  = {6'b0, o_hum_q, o_pv_q, o_pres_q, o_temp_q};

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_AA;
			ph_q    <= 2'd0;
			cnt_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			if (out_load)              ov_q <= 1'b1;
			else if (ov_q && m_tready) ov_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						a_q     <= 64'($signed(q_data.tfine)) - 64'd128000;
						temp_q  <= q_data.temperature;
						hum_q   <= q_data.humidity;
						rp_q    <= q_data.raw_press;
						op_q    <= OP_AA;
						ph_q    <= 2'd0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					ph_q <= ph_q + 2'd1;
					case (ph_q)
						2'd0: pp_q <= mp;
						2'd1: begin acc_q <= pp_q; pp_q <= mp; end
						2'd2: begin acc_q <= acc_q + {pp_q[31:0], 32'b0}; pp_q <= mp; end
						default: begin
							op_q <= op_t'(op_q + 4'd1);
							case (op_q)
								OP_AA: aa_q <= prod;
								OP_B6: b_q  <= prod;
								OP_B5: b_q  <= b_q + (prod << 17) + (p4 << 35);
								OP_C3: c_q  <= 64'($signed(prod) >>> 8);
								OP_C2: c_q  <= c_q + (prod << 12) + (64'd1 << 47);
								OP_X1: x_q  <= 64'($signed(prod) >>> 33);
								OP_NUM: begin
									if (x_q == '0) begin
										pv_q    <= 1'b0;
										state_q <= ST_FIN;
									end else begin
										pv_q    <= 1'b1;
										na_q    <= prod[63];
										nb_q    <= x_q[63];
										dvd_q   <= prod[63] ? -prod : prod;
										dvs_q   <= x_q[63] ? -x_q : x_q;
										rem_q   <= '0;
										cnt_q   <= '0;
										state_q <= ST_DIV;
									end
								end
								OP_Q9: c_q <= prod;
								OP_QQ: c_q <= 64'($signed(prod) >>> 25);
								OP_P8: begin
									c_q     <= pq_q + c_q + 64'($signed(prod) >>> 19);
									state_q <= ST_FIN;
								end
								default: state_q <= ST_IDLE;
							endcase
						end
					endcase
				end
				ST_DIV: begin
					rem_q <= dge ? dr_sub[63:0] : dr[63:0];
					dvd_q <= quo;
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63) begin
						pq_q    <= (na_q ^ nb_q) ? -quo : quo;
						op_q    <= OP_Q9;
						ph_q    <= 2'd0;
						state_q <= ST_MUL;
					end
				end
				ST_FIN: begin
					if (out_load) begin
						o_temp_q <= temp_q;
						o_hum_q  <= hum_q;
						o_pv_q   <= pv_q;
						o_pres_q <= pv_q ? pres_sat : 32'd0;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`ESC_ASSERT_IMP(a_div_nonzero, clk, arst_n, state_q == ST_DIV, dvs_q != '0, "divide by zero")
	`ESC_ASSERT_IMP(a_invalid_zero, clk, arst_n, ov_q && !o_pv_q, o_pres_q == '0, "invalid pressure not zero")

endmodule

[rtl/env_sensor_compensation_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// env_sensor_compensation_unit
// Integer compensation of raw temperature, pressure and humidity samples.
// ----------------------------------------------------------------------------
// A sample beat is taken every cycle, unless a full queue stalls the front,
// into a nine-stage front pipeline that computes the fine temperature,
// temperature and humidity; results wait in a short queue for the pressure
// back end, which runs ten 64-bit products on one 32x32 multiplier, a
// restoring divide, then load and output, without the divide and last three
// products for a zero divisor, and sets the sustained rate. Calibration must
// be written through cfg_we/cfg_index/cfg_wdata while idle; not enforced.
module env_sensor_compensation_unit #(
	parameter int QUEUE_DEPTH = esc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// raw_press [19:0], raw_temp [39:20], raw_hum [55:40]
	input  logic [esc_pkg::IN_DATA_W-1:0]  s_tdata,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// temperature [23:0], pressure [55:24], press_valid [56], humidity [73:57]
	output logic [esc_pkg::OUT_DATA_W-1:0] m_tdata,
	input  logic                           cfg_we,
	input  logic [esc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [esc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	esc_pkg::calib_t     calib_q;
	esc_pkg::front_res_t f_data, q_rdata;
	logic                f_push, q_full, q_empty, q_pop;

	// calibration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			calib_q <= '0;
		end else if (cfg_we) begin
			case (esc_pkg::reg_idx_t'(cfg_index))
				esc_pkg::REG_TEMP_CALIB: calib_q.temp <= cfg_wdata;
				esc_pkg::REG_PRESS_1_3:  calib_q.p13  <= cfg_wdata;
				esc_pkg::REG_PRESS_4_6:  calib_q.p46  <= cfg_wdata;
				esc_pkg::REG_PRESS_7_9:  calib_q.p79  <= cfg_wdata;
				esc_pkg::REG_HUM_1_3:    calib_q.h13  <= cfg_wdata[31:0];
				esc_pkg::REG_HUM_4_6:    calib_q.h46  <= cfg_wdata[31:0];
				default: ;
			endcase
		end
	end

	esc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.calib    (calib_q),
		.q_full   (q_full),
		.q_push   (f_push),
		.q_data   (f_data)
	);

	esc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_push),
		.wdata  (f_data),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	esc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.calib    (calib_q),
		.q_empty  (q_empty),
		.q_data   (q_rdata),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

[bench/tb_env_sensor_compensation_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_env_sensor_compensation_unit
// Self-checking bench for the sensor compensation unit: raw sample beats are
// compensated by a local integer model and compared field by field with the
// result beats, across several calibration sets written between phases.
// ----------------------------------------------------------------------------
module tb_env_sensor_compensation_unit;

	typedef struct packed {
		logic [16:0] humidity;
		logic        press_valid;
		logic [31:0] pressure;
		logic [23:0] temperature;
	} comp_res_t;

	logic                           clk;
	logic                           arst_n;
	logic                           s_tvalid;
	logic                           s_tready;
	logic [esc_pkg::IN_DATA_W-1:0]  s_tdata;
	logic                           m_tvalid;
	logic                           m_tready;
	logic [esc_pkg::OUT_DATA_W-1:0] m_tdata;
	logic                           cfg_we;
	logic [esc_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [esc_pkg::CFG_DATA_W-1:0] cfg_wdata;

	// local copy of the calibration words
	logic [47:0] cal_t, cal_p13, cal_p46, cal_p79;
	logic [31:0] cal_h13, cal_h46;

	logic [esc_pkg::IN_DATA_W-1:0] sample_q[$];
	comp_res_t                     result_q[$];
	int                            errors;
	int                            beats_out;
	int                            stall_cnt;
	bit                            calm;
	bit                            hold_tx;

	env_sensor_compensation_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic signed [63:0] sx(logic [63:0] v, int w);
		logic [63:0] m;
		m = 64'd1 << (w - 1);
		v = v & ((m << 1) - 64'd1);
		return $signed((v ^ m) - m);
	endfunction

	// integer compensation of one raw sample
	function automatic comp_res_t compensate(logic [esc_pkg::IN_DATA_W-1:0] raw);
		logic signed [31:0] t1, t2, t3, v1, dd, v2, tfine, tc;
		logic signed [31:0] h1, h2, h3, h4, h5, h6, hv, hx, hy, hs;
		logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
		logic signed [63:0] a, b, p, q, c1, c2;
		logic [31:0] adc_p, adc_t, adc_h;
		comp_res_t r;
		adc_p = 32'(raw[19:0]);
		adc_t = 32'(raw[39:20]);
		adc_h = 32'(raw[55:40]);
		t1 = 32'(cal_t[15:0]);
		t2 = 32'(sx(64'(cal_t[31:16]), 16));
		t3 = 32'(sx(64'(cal_t[47:32]), 16));
		v1 = ($signed((adc_t >> 3) - (t1 << 1)) * t2) >>> 11;
		dd = $signed((adc_t >> 4) - t1);
		v2 = (((dd * dd) >>> 12) * t3) >>> 14;
		tfine = v1 + v2;
		tc = (tfine * 5 + 128) >>> 8;
		if (tc < -32'sd8388608) tc = -32'sd8388608;
		else if (tc > 32'sd8388607) tc = 32'sd8388607;
		r.temperature = tc[23:0];

		p1 = 64'(cal_p13[15:0]);
		p2 = sx(64'(cal_p13[31:16]), 16);
		p3 = sx(64'(cal_p13[47:32]), 16);
		p4 = sx(64'(cal_p46[15:0]), 16);
		p5 = sx(64'(cal_p46[31:16]), 16);
		p6 = sx(64'(cal_p46[47:32]), 16);
		p7 = sx(64'(cal_p79[15:0]), 16);
		p8 = sx(64'(cal_p79[31:16]), 16);
		p9 = sx(64'(cal_p79[47:32]), 16);
		a = 64'(tfine) - 64'sd128000;
		b = a * a * p6;
		b = b + ((a * p5) <<< 17);
		b = b + (p4 <<< 35);
		a = ((a * a * p3) >>> 8) + ((a * p2) <<< 12);
		a = (((64'sd1 <<< 47) + a) * p1) >>> 33;
		r.pressure = '0;
		r.press_valid = 1'b0;
		if (a != 0) begin
			p = 64'sd1048576 - 64'(adc_p);
			p = (((p <<< 31) - b) * 64'sd3125) / a;
			q = p >>> 13;
			c1 = (p9 * q * q) >>> 25;
			c2 = (p8 * p) >>> 19;
			p = ((p + c1 + c2) >>> 8) + (p7 <<< 4);
			if (p < 0) r.pressure = '0;
			else if (p > 64'sd4294967295) r.pressure = 32'hFFFF_FFFF;
			else r.pressure = p[31:0];
			r.press_valid = 1'b1;
		end

		h1 = 32'(cal_h13[7:0]);
		h2 = 32'(sx(64'(cal_h13[23:8]), 16));
		h3 = 32'(cal_h13[31:24]);
		h4 = 32'(sx(64'(cal_h46[11:0]), 12));
		h5 = 32'(sx(64'(cal_h46[23:12]), 12));
		h6 = 32'(sx(64'(cal_h46[31:24]), 8));
		hv = tfine - 32'sd76800;
		hx = ($signed(adc_h << 14) - (h4 <<< 20) - h5 * hv + 32'sd16384) >>> 15;
		hy = ((hv * h6) >>> 10) * (((hv * h3) >>> 11) + 32'sd32768);
		hy = ((((hy >>> 10) + 32'sd2097152) * h2) + 32'sd8192) >>> 14;
		hv = hx * hy;
		hs = hv >>> 15;
		hv = hv - ((((hs * hs) >>> 7) * h1) >>> 4);
		if (hv < 0) hv = '0;
		else if (hv > 32'sd419430400) hv = 32'sd419430400;
		r.humidity = hv[28:12];
		return r;
	endfunction

	// one register write, block idle
	task automatic write_reg(esc_pkg::reg_idx_t idx, logic [47:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			esc_pkg::REG_TEMP_CALIB: cal_t   = val;
			esc_pkg::REG_PRESS_1_3:  cal_p13 = val;
			esc_pkg::REG_PRESS_4_6:  cal_p46 = val;
			esc_pkg::REG_PRESS_7_9:  cal_p79 = val;
			esc_pkg::REG_HUM_1_3:    cal_h13 = val[31:0];
			esc_pkg::REG_HUM_4_6:    cal_h46 = val[31:0];
			default: ;
		endcase
	endtask

	task automatic load_calib(logic [47:0] t, logic [47:0] a, logic [47:0] b,
			logic [47:0] c, logic [31:0] h, logic [31:0] g);
		write_reg(esc_pkg::REG_TEMP_CALIB, t);
		write_reg(esc_pkg::REG_PRESS_1_3, a);
		write_reg(esc_pkg::REG_PRESS_4_6, b);
		write_reg(esc_pkg::REG_PRESS_7_9, c);
		write_reg(esc_pkg::REG_HUM_1_3, {16'd0, h});
		write_reg(esc_pkg::REG_HUM_4_6, {16'd0, g});
	endtask

	// wait until every queued sample has been sent and its result checked
	task automatic drain();
		while (sample_q.size() != 0 || s_tvalid || result_q.size() != 0)
			@(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	function automatic logic [esc_pkg::IN_DATA_W-1:0] rnd_sample();
		return {16'($urandom), 20'($urandom), 20'($urandom)};
	endfunction

	// sample driver
	always @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			result_q.push_back(compensate(s_tdata));
		end
		if (!(s_tvalid && !s_tready)) begin
			if (sample_q.size() != 0 && !hold_tx && (calm || $urandom_range(99) >= 11)) begin
				s_tdata  <= sample_q.pop_front();
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// result monitor and checker
	always @(posedge clk) begin
		comp_res_t got, want;
		m_tready <= calm || $urandom_range(99) >= 11;
		if (m_tvalid && m_tready) begin
			got = m_tdata[73:0];
			beats_out++;
			if (result_q.size() == 0) begin
				$error("result beat with nothing expected");
				errors++;
			end else begin
				want = result_q.pop_front();
				if (got.temperature !== want.temperature) begin
					$error("temperature expected %0d got %0d",
						$signed(want.temperature), $signed(got.temperature));
					errors++;
				end
				if (got.pressure !== want.pressure) begin
					$error("pressure expected %0d got %0d", want.pressure, got.pressure);
					errors++;
				end
				if (got.press_valid !== want.press_valid) begin
					$error("press_valid expected %0d got %0d",
						want.press_valid, got.press_valid);
					errors++;
				end
				if (got.humidity !== want.humidity) begin
					$error("humidity expected %0d got %0d", want.humidity, got.humidity);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles without any beat
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			stall_cnt <= 0;
		else
			stall_cnt <= stall_cnt + 1;
		if (stall_cnt > 20000) begin
			$display("tb_env_sensor_compensation_unit failed");
			$finish;
		end
	end

	// typical calibration set
	localparam logic [47:0] T_TYP  = {16'sd50, 16'sd26435, 16'd27504};
	localparam logic [47:0] P13TYP = {-16'sd4223, -16'sd10685, 16'd36477};
	localparam logic [47:0] P46TYP = {-16'sd7, 16'sd140, 16'sd2855};
	localparam logic [47:0] P79TYP = {16'sd4285, -16'sd10230, 16'sd15500};
	localparam logic [31:0] H13TYP = {8'd0, 16'sd363, 8'd75};
	localparam logic [31:0] H46TYP = {8'sd30, 12'sd50, 12'sd313};

	initial begin
		errors = 0; beats_out = 0; stall_cnt = 0;
		calm = 1'b0; hold_tx = 1'b0;
		s_tvalid = 1'b0; s_tdata = '0; m_tready = 1'b0;
		cfg_we = 1'b0; cfg_index = '0; cfg_wdata = '0;
		cal_t = '0; cal_p13 = '0; cal_p46 = '0; cal_p79 = '0; cal_h13 = '0; cal_h46 = '0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset calibration: divisor is zero
		sample_q.push_back({16'd0, 20'd0, 20'd0});
		sample_q.push_back({16'hFFFF, 20'hFFFFF, 20'hFFFFF});
		drain();

		// typical calibration, field extremes
		load_calib(T_TYP, P13TYP, P46TYP, P79TYP, H13TYP, H46TYP);
		sample_q.push_back({16'd0, 20'd0, 20'd0});
		sample_q.push_back({16'hFFFF, 20'hFFFFF, 20'hFFFFF});
		sample_q.push_back({16'd0, 20'hFFFFF, 20'd0});
		sample_q.push_back({16'hFFFF, 20'd0, 20'hFFFFF});
		sample_q.push_back({16'd27000, 20'd519888, 20'd415148});
		sample_q.push_back({16'hAAAA, 20'h55555, 20'hAAAAA});
		sample_q.push_back({16'h5555, 20'hAAAAA, 20'h55555});
		drain();

		// extreme calibration words: saturation and wrap
		load_calib('1, '1, '1, '1, '1, '1);
		repeat (4) sample_q.push_back(rnd_sample());
		sample_q.push_back({16'hFFFF, 20'hFFFFF, 20'd0});
		drain();
		load_calib({16'h7FFF, 16'h7FFF, 16'h0}, {16'h8000, 16'h7FFF, 16'hFFFF},
			{16'h7FFF, 16'h8000, 16'h7FFF}, {16'h8000, 16'h7FFF, 16'h8000},
			32'hFF7FFFFF, 32'h807FF800);
		repeat (4) sample_q.push_back(rnd_sample());
		sample_q.push_back({16'd0, 20'd0, 20'hFFFFF});
		drain();

		// random phases under varied calibration
		for (int ph = 0; ph < 5; ph++) begin
			if (ph == 2)
				load_calib(T_TYP, P13TYP, P46TYP, P79TYP, H13TYP, H46TYP);
			else
				load_calib({$urandom, 16'($urandom)}, {$urandom, 16'($urandom)},
					{$urandom, 16'($urandom)}, {$urandom, 16'($urandom)},
					$urandom, $urandom);
			calm = (ph == 3);
			for (int k = 0; k < 90; k++) begin
				sample_q.push_back(ph == 2 ? {16'($urandom_range(20000, 45000)),
					20'($urandom_range(400000, 600000)),
					20'($urandom_range(200000, 500000))} : rnd_sample());
				if (k == 45) begin
					// hold the sender until everything is back
					while (sample_q.size() != 0 || s_tvalid) @(posedge clk);
					hold_tx = 1'b1;
					while (result_q.size() != 0) @(posedge clk);
					hold_tx = 1'b0;
				end
			end
			drain();
		end
		calm = 1'b0;

		$display("Covered reset, typical, extreme and random calibration sets; %0d result beats.",
			beats_out);
		if (errors == 0)
			$display("tb_env_sensor_compensation_unit passed");
		else
			$display("tb_env_sensor_compensation_unit failed");
		$finish;
	end

endmodule
